// File: hw/rtl/odbp_pkg.sv
`default_nettype none
package odbp_pkg;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    CFG_VOXEL_X = 3'd0,
    CFG_VOXEL_Y = 3'd1,
    CFG_VOXEL_Z = 3'd2,
    CFG_IN_FOV  = 3'd3,
    CFG_INIT    = 3'd4,
    CFG_COUNT   = 3'd5
  } cfg_idx_t;

  // event fields after the front checks
  typedef struct packed {
    logic        use_it;
    logic [31:0] ady;
    logic [31:0] adz;
    logic [30:0] pz;
    logic [30:0] pxy;
    logic signed [31:0] tw;
    logic signed [31:0] nrm;
  } work_t;
endpackage
`default_nettype wire

// File: hw/rtl/odbp_if.sv
`default_nettype none
interface odbp_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] plane_a, plane_b, plane_c, plane_d;
  logic signed [31:0] normal_a, normal_b, normal_c, normal_d;
  logic [30:0] pitch_xy, pitch_z;
  logic signed [31:0] time_weight, event_norm;
  modport source (output valid, plane_a, plane_b, plane_c, plane_d, normal_a, normal_b,
                  normal_c, normal_d, pitch_xy, pitch_z, time_weight, event_norm,
                  input ready);
  modport sink (input valid, plane_a, plane_b, plane_c, plane_d, normal_a, normal_b,
                normal_c, normal_d, pitch_xy, pitch_z, time_weight, event_norm,
                output ready);
endinterface

interface odbp_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] coefficient;
  logic run_last;
  modport source (output valid, coefficient, run_last, input ready);
  modport sink (input valid, coefficient, run_last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/odbp_front.sv
`default_nettype none
// computes plane distances over several steps, pushes a work item
module odbp_front (
  input  wire logic clk,
  input  wire logic rst_n,
  odbp_in_if.sink   in_ch,
  input  wire logic signed [15:0] vx,
  input  wire logic signed [15:0] vy,
  input  wire logic signed [15:0] vz,
  input  wire logic fov,
  output odbp_pkg::work_t wk,
  output logic      wk_valid,
  input  wire logic wk_ready
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MUL = 4'b0010, S_SUM = 4'b0100, S_OUT = 4'b1000
  } st_t;
  st_t st_r, st_nxt;
  logic [2:0] k_r;
  logic signed [31:0] pl_r [8];
  logic [30:0] pxy_r, pz_r;
  logic signed [31:0] tw_r, nrm_r;
  logic signed [49:0] prod_r [6];
  logic signed [51:0] dz_r, dy_r;
  logic signed [31:0] mul_a;
  logic signed [15:0] mul_b;
  logic [51:0] ady, adz;

  assign in_ch.ready = (st_r == S_IDLE);
  assign wk_valid = (st_r == S_OUT);

  // one multiplier, shared over six products
  always_comb begin
    case (k_r)
      3'd0: begin mul_a = pl_r[0]; mul_b = vx; end
      3'd1: begin mul_a = pl_r[1]; mul_b = vy; end
      3'd2: begin mul_a = pl_r[2]; mul_b = vz; end
      3'd3: begin mul_a = pl_r[4]; mul_b = vx; end
      3'd4: begin mul_a = pl_r[5]; mul_b = vy; end
      3'd5: begin mul_a = pl_r[6]; mul_b = vz; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_ch.valid) st_nxt = S_MUL;
      S_MUL: if (k_r == 3'd5) st_nxt = S_SUM;
      S_SUM: st_nxt = S_OUT;
      S_OUT: if (wk_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      k_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_MUL) k_r <= k_r + 3'd1;
      else k_r <= '0;
    end
  end

  // payload capture and distance sums
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_ch.valid) begin
      pl_r[0] <= in_ch.plane_a;  pl_r[1] <= in_ch.plane_b;
      pl_r[2] <= in_ch.plane_c;  pl_r[3] <= in_ch.plane_d;
      pl_r[4] <= in_ch.normal_a; pl_r[5] <= in_ch.normal_b;
      pl_r[6] <= in_ch.normal_c; pl_r[7] <= in_ch.normal_d;
      pxy_r <= in_ch.pitch_xy; pz_r <= in_ch.pitch_z;
      tw_r <= in_ch.time_weight; nrm_r <= in_ch.event_norm;
    end
    if (st_r == S_MUL) prod_r[k_r] <= 50'(mul_a * mul_b);
    if (st_r == S_SUM) begin
      dz_r <= 52'(prod_r[0]) + 52'(prod_r[1]) + 52'(prod_r[2]) - 52'(pl_r[3]);
      dy_r <= 52'(prod_r[3]) + 52'(prod_r[4]) + 52'(prod_r[5]) - 52'(pl_r[7]);
    end
  end

  assign ady = dy_r[51] ? 52'(-dy_r) : dy_r;
  assign adz = dz_r[51] ? 52'(-dz_r) : dz_r;

  // classification
  always_comb begin
    wk.use_it = fov && (pxy_r != '0) && (pz_r != '0) && (ady <= 52'(pz_r))
                && (adz <= 52'(pxy_r)) && (nrm_r != '0);
    wk.ady = ady[31:0];
    wk.adz = adz[31:0];
    wk.pz = pz_r;
    wk.pxy = pxy_r;
    wk.tw = tw_r;
    wk.nrm = nrm_r;
  end

`ifndef ASSERT_OFF
  a_one_st: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("front state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    wk_valid && !wk_ready |=> wk_valid) else $error("work item dropped");
  a_k: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_MUL |=> k_r == 3'd0 || st_r == S_MUL) else $error("product index stale");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/odbp_fifo.sv
`default_nettype none
// short queue between front and back
module odbp_fifo (
  input  wire logic clk,
  input  wire logic rst_n,
  input  odbp_pkg::work_t d_in,
  input  wire logic in_valid,
  output logic      in_ready,
  output odbp_pkg::work_t d_out,
  output logic      out_valid,
  input  wire logic out_ready
);
  odbp_pkg::work_t mem_r [odbp_pkg::FIFO_DEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign d_out = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= d_in;
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r) else $error("pointer mismatch");
  a_stay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !push |=> out_valid) else $error("queue lost entry");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/odbp_back.sv
`default_nettype none
// ratios, root, scaled divide, then accumulate
module odbp_back #(
  parameter int FRACTION_BITS = odbp_pkg::FRACTION_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  odbp_pkg::work_t wk,
  input  wire logic wk_valid,
  output logic      wk_ready,
  input  wire logic signed [31:0] init_coef,
  input  wire logic [23:0] ev_count,
  odbp_out_if.source out_ch
);
  localparam int RW = 32 + FRACTION_BITS;   // ratio dividend width
  localparam int SW = 2 * RW + 2;           // sum of squares width
  localparam int RTW = SW / 2;              // root width
  localparam int PW = 32 + FRACTION_BITS + 2; // product width
  localparam int QW = FRACTION_BITS + 1;    // ratio width, ratios never exceed one
  localparam int CW = 7;

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001, B_DIVY = 7'b0000010, B_DIVZ = 7'b0000100,
    B_SQ = 7'b0001000, B_ROOT = 7'b0010000, B_DIVC = 7'b0100000,
    B_OUT = 7'b1000000
  } bst_t;
  bst_t st_r, st_nxt;

  odbp_pkg::work_t w_r;
  logic [CW-1:0] cnt_r;
  // shared restoring divider
  logic [RW-1:0] q_r;
  logic [RW:0] rem_r;
  logic [QW-1:0] ry_r, rz_r;
  logic [RW:0] rem_sh;
  logic [RW-1:0] dvs;
  // root
  logic [SW-1:0] sq_r, root_rem_r;
  logic [RTW-1:0] root_r;
  logic [SW-1:0] trial;
  logic [SW-1:0] rr_sh;
  logic [2*QW-1:0] sq_a, sq_p;
  // contribution
  logic neg_r, is_zero_r;
  logic [FRACTION_BITS+1:0] fac;
  logic [31:0] tw_mag;
  logic [PW-1:0] cprod;
  logic [PW-1:0] crem_sh;
  logic [PW-1:0] cq_r;
  logic [PW:0] crem_r;
  logic [31:0] nrm_mag;
  // accumulate
  logic [23:0] ecnt_r;
  logic signed [31:0] acc_r;
  logic signed [63:0] contrib, base, sum;
  logic [23:0] ecnt_inc;
  logic last;
  logic signed [31:0] sumsat;

  assign wk_ready = (st_r == B_IDLE);
  assign dvs = (st_r == B_DIVY) ? RW'(w_r.pz) : RW'(w_r.pxy);
  assign rem_sh = {rem_r[RW-1:0], q_r[RW-1]};
  assign sq_a = (st_r == B_SQ && cnt_r == '0) ? (2*QW)'(ry_r) : (2*QW)'(rz_r);
  assign sq_p = sq_a * sq_a;
  assign rr_sh = {root_rem_r[SW-3:0], sq_r[SW-1:SW-2]};
  assign trial = SW'({root_r, 2'b01});
  assign fac = (FRACTION_BITS+2)'(1 << FRACTION_BITS) - (FRACTION_BITS+2)'(root_r);
  assign tw_mag = w_r.tw[31] ? 32'(-w_r.tw) : 32'(w_r.tw);
  assign cprod = PW'(tw_mag) * PW'(fac);
  assign nrm_mag = w_r.nrm[31] ? 32'(-w_r.nrm) : 32'(w_r.nrm);
  assign crem_sh = {crem_r[PW-2:0], cq_r[PW-1]};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: if (wk_valid) st_nxt = wk.use_it ? B_DIVY : B_OUT;
      B_DIVY: if (cnt_r == CW'(RW-1)) st_nxt = B_DIVZ;
      B_DIVZ: if (cnt_r == CW'(RW-1)) st_nxt = B_SQ;
      B_SQ: if (cnt_r == CW'(2)) st_nxt = B_ROOT;
      B_ROOT: if (cnt_r == CW'(RTW-1)) st_nxt = B_DIVC;
      B_DIVC: if (cnt_r == CW'(PW) || is_zero_r) st_nxt = B_OUT;
      B_OUT: if (!out_ch.valid || out_ch.ready) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= B_IDLE;
    else st_r <= st_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (st_r != st_nxt) cnt_r <= '0;
    else cnt_r <= cnt_r + CW'(1);
    case (st_r)
      B_IDLE: begin
        w_r <= wk;
        q_r <= {wk.ady, FRACTION_BITS'(0)};
        rem_r <= '0;
        is_zero_r <= 1'b0;
      end
      B_DIVY, B_DIVZ: begin
        if (cnt_r == CW'(RW-1)) begin
          // last quotient bit, then load the second dividend
          rem_r <= '0;
          q_r <= {w_r.adz, FRACTION_BITS'(0)};
          if (st_r == B_DIVY) ry_r <= QW'({q_r[RW-2:0], rem_sh >= {1'b0, dvs}});
          else rz_r <= QW'({q_r[RW-2:0], rem_sh >= {1'b0, dvs}});
        end else if (rem_sh >= {1'b0, dvs}) begin
          rem_r <= rem_sh - {1'b0, dvs};
          q_r <= {q_r[RW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r <= {q_r[RW-2:0], 1'b0};
        end
      end
      B_SQ: begin
        // squares of ratios, one per cycle, then sum
        if (cnt_r == '0) sq_r <= SW'(sq_p);
        else if (cnt_r == CW'(1)) sq_r <= sq_r + SW'(sq_p);
        root_r <= '0;
        root_rem_r <= '0;
      end
      B_ROOT: begin
        if (rr_sh >= trial) begin
          root_rem_r <= rr_sh - trial;
          root_r <= {root_r[RTW-2:0], 1'b1};
        end else begin
          root_rem_r <= rr_sh;
          root_r <= {root_r[RTW-2:0], 1'b0};
        end
        sq_r <= {sq_r[SW-3:0], 2'b00};
      end
      B_DIVC: begin
        if (cnt_r == '0) begin
          if (root_r >= RTW'(1 << FRACTION_BITS)) is_zero_r <= 1'b1;
          neg_r <= w_r.tw[31] ^ w_r.nrm[31];
          cq_r <= cprod;
          crem_r <= '0;
        end else begin
          if (crem_sh >= PW'(nrm_mag)) begin
            crem_r <= {1'b0, crem_sh - PW'(nrm_mag)};
            cq_r <= {cq_r[PW-2:0], 1'b1};
          end else begin
            crem_r <= {1'b0, crem_sh};
            cq_r <= {cq_r[PW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // divider runs PW steps after its setup cycle, unless the root is at least one, which ends it early
  always_comb begin
    if (!w_r.use_it || is_zero_r) contrib = '0;
    else contrib = neg_r ? -64'(cq_r) : 64'(cq_r);
    base = (ecnt_r == '0) ? 64'(init_coef) : 64'(acc_r);
    sum = base + contrib;
    if (sum > 64'sd2147483647) sumsat = 32'sh7fffffff;
    else if (sum < -64'sd2147483648) sumsat = 32'sh80000000;
    else sumsat = sum[31:0];
    ecnt_inc = ecnt_r + 24'd1;
    last = (ecnt_inc >= ev_count) || (ecnt_inc == '0);
  end

  // result register and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
      ecnt_r <= '0;
      acc_r <= '0;
    end else begin
      if (st_r == B_OUT && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
        out_ch.coefficient <= sumsat;
        out_ch.run_last <= last;
        ecnt_r <= last ? '0 : ecnt_inc;
        acc_r <= last ? init_coef : sumsat;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_one: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("back state not one-hot");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.run_last |=> ecnt_r == '0 || $past(st_r) == B_OUT)
    else $error("run did not restart");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_OUT && out_ch.valid && !out_ch.ready |=> st_r == B_OUT)
    else $error("result overwritten");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/orthogonal_distance_backprojection.sv
`default_nettype none
// flow: the front computes six shared multiplies per event and pushes it into
//   the queue; the back takes one event at a time and, for a contributing one,
//   runs two ratio divides, root and final divide, all serial, while a skipped
//   event goes straight to its output; the front can run up to three events
//   ahead through the queue
// reset: synchronous active-low rst_n clears control, coefficient to zero,
//   event count to one; no clearing pass
module orthogonal_distance_backprojection #(
  parameter int FRACTION_BITS = odbp_pkg::FRACTION_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  odbp_in_if.sink   in_ch,
  odbp_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic signed [15:0] vx_r, vy_r, vz_r;
  logic fov_r;
  logic signed [31:0] init_r;
  logic [23:0] cnt_r;
  odbp_pkg::work_t f_wk, b_wk;
  logic f_v, f_r, b_v, b_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= '0; vy_r <= '0; vz_r <= '0; fov_r <= 1'b0;
      init_r <= '0; cnt_r <= 24'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        odbp_pkg::CFG_VOXEL_X: vx_r <= cfg_data[15:0];
        odbp_pkg::CFG_VOXEL_Y: vy_r <= cfg_data[15:0];
        odbp_pkg::CFG_VOXEL_Z: vz_r <= cfg_data[15:0];
        odbp_pkg::CFG_IN_FOV:  fov_r <= cfg_data[0];
        odbp_pkg::CFG_INIT:    init_r <= cfg_data;
        odbp_pkg::CFG_COUNT:   cnt_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  odbp_front u_front (.clk, .rst_n, .in_ch, .vx(vx_r), .vy(vy_r), .vz(vz_r),
    .fov(fov_r), .wk(f_wk), .wk_valid(f_v), .wk_ready(f_r));

  odbp_fifo u_fifo (.clk, .rst_n, .d_in(f_wk), .in_valid(f_v), .in_ready(f_r),
    .d_out(b_wk), .out_valid(b_v), .out_ready(b_r));

  odbp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (.clk, .rst_n, .wk(b_wk),
    .wk_valid(b_v), .wk_ready(b_r), .init_coef(init_r), .ev_count(cnt_r), .out_ch);
endmodule
`default_nettype wire
